[design/eight_bit_alu_with_flags_macros.svh]
// Assertion macros used by the checker file of the eight-bit ALU.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH

// Checked only while reset is low.
`define EBALU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ALU port check failed");

// Checked at every edge, including those in reset.
`define EBALU_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ALU reset check failed");

`endif

[design/ebalu_pkg.sv]
// Package with the opcodes and shared types of the eight-bit ALU.
package ebalu_pkg;

   localparam logic [4:0] OP_ADD       = 5'd0;
   localparam logic [4:0] OP_ADC       = 5'd1;
   localparam logic [4:0] OP_SUB       = 5'd2;
   localparam logic [4:0] OP_SBC       = 5'd3;
   localparam logic [4:0] OP_AND       = 5'd4;
   localparam logic [4:0] OP_XOR       = 5'd5;
   localparam logic [4:0] OP_OR        = 5'd6;
   localparam logic [4:0] OP_CP        = 5'd7;
   localparam logic [4:0] OP_INC       = 5'd8;
   localparam logic [4:0] OP_DEC       = 5'd9;
   localparam logic [4:0] OP_RLC       = 5'd10;
   localparam logic [4:0] OP_RRC       = 5'd11;
   localparam logic [4:0] OP_RL        = 5'd12;
   localparam logic [4:0] OP_RR        = 5'd13;
   localparam logic [4:0] OP_SLA       = 5'd14;
   localparam logic [4:0] OP_SRA       = 5'd15;
   localparam logic [4:0] OP_SWAP      = 5'd16;
   localparam logic [4:0] OP_SRL       = 5'd17;
   localparam logic [4:0] OP_BIT       = 5'd18;
   localparam logic [4:0] OP_RES       = 5'd19;
   localparam logic [4:0] OP_SET       = 5'd20;
   localparam logic [4:0] OP_DAA       = 5'd21;
   localparam logic [4:0] OP_CPL       = 5'd22;
   localparam logic [4:0] OP_CCF       = 5'd23;
   localparam logic [4:0] OP_SCF       = 5'd24;
   localparam logic [4:0] OP_ADD16     = 5'd25;
   localparam logic [4:0] OP_SP_OFFSET = 5'd26;

   typedef struct packed {
      logic [4:0]  op;
      logic [7:0]  operand;
      logic [2:0]  bit_index;
      logic [15:0] wide_base;
      logic [15:0] wide_operand;
   } alu_req_type;

   typedef struct packed {
      logic [7:0] acc;
      logic       zero;
      logic       subtract;
      logic       half_carry;
      logic       carry;
   } state_type;

   typedef struct packed {
      logic [7:0]  result_value;
      logic [15:0] wide_result;
      logic        zero;
      logic        subtract;
      logic        half_carry;
      logic        carry;
   } rsp_type;

endpackage

[design/ebalu_core.sv]
// Single-pass ALU datapath: one request and the current state give the result and next state.
module ebalu_core
   import ebalu_pkg::*;
(
   input  alu_req_type req,
   input  state_type   state,
   output rsp_type     rsp,
   output state_type   state_next
);

   logic [7:0]  a;
   logic [7:0]  r;
   logic        c;
   logic        cin;
   logic [8:0]  sum9;
   logic [4:0]  sum_lo;
   logic [8:0]  diff9;
   logic [4:0]  diff_lo;
   logic [7:0]  daa_val;
   logic        daa_carry;
   logic [16:0] add16_sum;
   logic [12:0] add16_lo;
   logic [15:0] sp_sum;
   logic [8:0]  sp_lo8;
   logic [4:0]  sp_lo4;

   assign a = state.acc;
   assign r = req.operand;
   assign c = state.carry;

   assign cin     = ((req.op == OP_ADC) || (req.op == OP_SBC)) ? c : 1'b0;
   assign sum9    = {1'b0, a} + {1'b0, r} + {8'd0, cin};
   assign sum_lo  = {1'b0, a[3:0]} + {1'b0, r[3:0]} + {4'd0, cin};
   assign diff9   = {1'b0, a} - {1'b0, r} - {8'd0, cin};
   assign diff_lo = {1'b0, a[3:0]} - {1'b0, r[3:0]} - {4'd0, cin};

   assign add16_sum = {1'b0, req.wide_base} + {1'b0, req.wide_operand};
   assign add16_lo  = {1'b0, req.wide_base[11:0]} + {1'b0, req.wide_operand[11:0]};
   assign sp_sum    = req.wide_base + {{8{r[7]}}, r};
   assign sp_lo8    = {1'b0, req.wide_base[7:0]} + {1'b0, r};
   assign sp_lo4    = {1'b0, req.wide_base[3:0]} + {1'b0, r[3:0]};

   // The low-nibble check in the add direction looks at the accumulator before
   // the high correction is applied.
   always_comb begin
      daa_val   = a;
      daa_carry = c;
      if (!state.subtract) begin
         if (c || (a > 8'h99)) begin
            daa_val   = daa_val + 8'h60;
            daa_carry = 1'b1;
         end
         if (state.half_carry || (a[3:0] > 4'h9)) begin
            daa_val = daa_val + 8'h06;
         end
      end else begin
         if (c) begin
            daa_val = daa_val - 8'h60;
         end
         if (state.half_carry) begin
            daa_val = daa_val - 8'h06;
         end
      end
   end

   always_comb begin
      rsp.result_value = a;
      rsp.wide_result  = 16'd0;
      rsp.zero         = state.zero;
      rsp.subtract     = state.subtract;
      rsp.half_carry   = state.half_carry;
      rsp.carry        = state.carry;
      state_next.acc   = a;
      case (req.op)
         OP_ADD, OP_ADC: begin
            rsp.result_value = sum9[7:0];
            rsp.half_carry   = sum_lo[4];
            rsp.carry        = sum9[8];
            rsp.subtract     = 1'b0;
            state_next.acc   = sum9[7:0];
         end
         OP_SUB, OP_SBC, OP_CP: begin
            rsp.result_value = (req.op == OP_CP) ? a : diff9[7:0];
            rsp.half_carry   = diff_lo[4];
            rsp.carry        = diff9[8];
            rsp.subtract     = 1'b1;
            if (req.op != OP_CP) begin
               state_next.acc = diff9[7:0];
            end
         end
         OP_AND, OP_XOR, OP_OR: begin
            if (req.op == OP_AND) begin
               rsp.result_value = a & r;
            end else if (req.op == OP_XOR) begin
               rsp.result_value = a ^ r;
            end else begin
               rsp.result_value = a | r;
            end
            rsp.subtract   = 1'b0;
            rsp.half_carry = (req.op == OP_AND);
            rsp.carry      = 1'b0;
            state_next.acc = rsp.result_value;
         end
         OP_INC: begin
            rsp.result_value = r + 8'd1;
            rsp.subtract     = 1'b0;
            rsp.half_carry   = (r[3:0] == 4'hF);
         end
         OP_DEC: begin
            rsp.result_value = r - 8'd1;
            rsp.subtract     = 1'b1;
            rsp.half_carry   = (r[3:0] == 4'h0);
         end
         OP_RLC: begin
            rsp.result_value = {r[6:0], r[7]};
            rsp.carry        = r[7];
         end
         OP_RRC: begin
            rsp.result_value = {r[0], r[7:1]};
            rsp.carry        = r[0];
         end
         OP_RL: begin
            rsp.result_value = {r[6:0], c};
            rsp.carry        = r[7];
         end
         OP_RR: begin
            rsp.result_value = {c, r[7:1]};
            rsp.carry        = r[0];
         end
         OP_SLA: begin
            rsp.result_value = {r[6:0], 1'b0};
            rsp.carry        = r[7];
         end
         OP_SRA: begin
            rsp.result_value = {r[7], r[7:1]};
            rsp.carry        = r[0];
         end
         OP_SWAP: begin
            rsp.result_value = {r[3:0], r[7:4]};
            rsp.carry        = 1'b0;
         end
         OP_SRL: begin
            rsp.result_value = {1'b0, r[7:1]};
            rsp.carry        = r[0];
         end
         OP_BIT: begin
            rsp.result_value = r;
            rsp.zero         = ~r[req.bit_index];
            rsp.subtract     = 1'b0;
            rsp.half_carry   = 1'b1;
         end
         OP_RES: begin
            rsp.result_value = r & ~(8'd1 << req.bit_index);
         end
         OP_SET: begin
            rsp.result_value = r | (8'd1 << req.bit_index);
         end
         OP_DAA: begin
            rsp.result_value = daa_val;
            rsp.half_carry   = 1'b0;
            rsp.carry        = daa_carry;
            state_next.acc   = daa_val;
         end
         OP_CPL: begin
            rsp.result_value = ~a;
            rsp.subtract     = 1'b1;
            rsp.half_carry   = 1'b1;
            state_next.acc   = ~a;
         end
         OP_CCF, OP_SCF: begin
            rsp.carry      = (req.op == OP_CCF) ? ~c : 1'b1;
            rsp.subtract   = 1'b0;
            rsp.half_carry = 1'b0;
         end
         OP_ADD16: begin
            rsp.result_value = 8'd0;
            rsp.wide_result  = add16_sum[15:0];
            rsp.subtract     = 1'b0;
            rsp.half_carry   = add16_lo[12];
            rsp.carry        = add16_sum[16];
         end
         OP_SP_OFFSET: begin
            rsp.result_value = 8'd0;
            rsp.wide_result  = sp_sum;
            rsp.zero         = 1'b0;
            rsp.subtract     = 1'b0;
            rsp.half_carry   = sp_lo4[4];
            rsp.carry        = sp_lo8[8];
         end
         default: begin
         end
      endcase

      // The rotates and shifts share their zero, subtract and half carry rule.
      if ((req.op >= OP_RLC) && (req.op <= OP_SRL)) begin
         rsp.subtract   = 1'b0;
         rsp.half_carry = 1'b0;
      end
      if (((req.op <= OP_SRL) && (req.op != OP_CP)) || (req.op == OP_DAA)) begin
         rsp.zero = (rsp.result_value == 8'd0);
      end else if (req.op == OP_CP) begin
         rsp.zero = (diff9[7:0] == 8'd0);
      end

      state_next.zero       = rsp.zero;
      state_next.subtract   = rsp.subtract;
      state_next.half_carry = rsp.half_carry;
      state_next.carry      = rsp.carry;
   end

endmodule

[design/eight_bit_alu_with_flags.sv]
// Top level of the eight-bit ALU with accumulator and flags.
// A request is registered on acceptance and passes through the ALU logic once on its way
// into the result register, which drives the result ports. One request is taken every
// cycle while the result side is not stalled: the accumulator and flags update on that
// same pass, so each request sees the state left by the one before it. While a finished
// result waits, the input register can still hold one more request, so the block stalls
// its input only when it holds two.
// Reset clears the accumulator and all four flags.
module eight_bit_alu_with_flags
   import ebalu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_type,
   input  logic [7:0]  req_operand,
   input  logic [2:0]  req_bit_index,
   input  logic [15:0] req_wide_base,
   input  logic [15:0] req_wide_operand,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_result_value,
   output logic [15:0] rsp_wide_result,
   output logic        rsp_zero_out,
   output logic        rsp_subtract_out,
   output logic        rsp_half_carry_out,
   output logic        rsp_carry_out
);

   logic        in_valid_ff;
   logic        in_valid_in;
   alu_req_type in_req_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_ff;
   state_type   state_ff;
   state_type   state_in;
   rsp_type     core_rsp;
   logic        out_free;
   logic        advance;
   logic        req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   ebalu_core u_core (
      .req        (in_req_ff),
      .state      (state_ff),
      .rsp        (core_rsp),
      .state_next (state_in)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff.op           <= req_type;
         in_req_ff.operand      <= req_operand;
         in_req_ff.bit_index    <= req_bit_index;
         in_req_ff.wide_base    <= req_wide_base;
         in_req_ff.wide_operand <= req_wide_operand;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = rsp_ff.result_value;
   assign rsp_wide_result    = rsp_ff.wide_result;
   assign rsp_zero_out       = rsp_ff.zero;
   assign rsp_subtract_out   = rsp_ff.subtract;
   assign rsp_half_carry_out = rsp_ff.half_carry;
   assign rsp_carry_out      = rsp_ff.carry;

endmodule

[design/ebalu_checker.sv]
// Port-level checks for the eight-bit ALU, bound to its top level.
`include "eight_bit_alu_with_flags_macros.svh"

module ebalu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_result_value,
   input logic [15:0] rsp_wide_result,
   input logic        rsp_subtract_out
);

   // A held result keeps its value.
   `EBALU_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_value)))

   // Reset leaves no result pending.
   `EBALU_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

   // With the result register empty there is always room for a request.
   `EBALU_ASSERT(a_no_stall_when_empty, clock, reset, (req_valid && !rsp_valid) |-> !req_stall)

   // A nonzero sixteen-bit sum comes only from the wide adds, which clear the byte and subtract.
   `EBALU_ASSERT(a_wide_only, clock, reset, (rsp_valid && (rsp_wide_result != 16'd0)) |-> ((rsp_result_value == 8'd0) && !rsp_subtract_out))

endmodule

bind eight_bit_alu_with_flags ebalu_checker u_ebalu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_value (rsp_result_value),
   .rsp_wide_result  (rsp_wide_result),
   .rsp_subtract_out (rsp_subtract_out)
);
